// ===== rtl/core/cbd_pkg.sv =====
// shared types and constants of the console bus decoder with sprite dma
// no dependencies; used by cbd_ctrl, cbd_datapath and the top level
`default_nettype none
package cbd_pkg;

    // default size of the internal work ram, mirrored across 0x0000-0x1fff
    localparam int RAM_BYTES_DEF = 2048;
    // span of the cpu address window that maps onto work ram
    localparam int RAM_SPAN = 8192;

    // request codes
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // decode targets
    localparam logic [2:0] TGT_NONE = 3'd0;
    localparam logic [2:0] TGT_CART = 3'd1;
    localparam logic [2:0] TGT_RAM  = 3'd2;
    localparam logic [2:0] TGT_PPU  = 3'd3;
    localparam logic [2:0] TGT_APU  = 3'd4;
    localparam logic [2:0] TGT_DMA  = 3'd5;
    localparam logic [2:0] TGT_PAD  = 3'd6;

    // address map
    localparam logic [15:0] ADDR_RAM_LAST = 16'h1FFF;
    localparam logic [15:0] ADDR_PPU_LAST = 16'h3FFF;
    localparam logic [15:0] ADDR_APU_LAST = 16'h4013;
    localparam logic [15:0] ADDR_OAM_DMA  = 16'h4014;
    localparam logic [15:0] ADDR_APU_STAT = 16'h4015;
    localparam logic [15:0] ADDR_PAD0     = 16'h4016;
    localparam logic [15:0] ADDR_PAD1     = 16'h4017;

    // tick phases of the cpu slot (counter runs modulo six)
    localparam logic [2:0] PHASE_EVEN = 3'd0;
    localparam logic [2:0] PHASE_ODD  = 3'd3;
    localparam logic [2:0] PHASE_LAST = 3'd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } cbd_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/cbd_ctrl.sv =====
// sequencing state machine of the console bus decoder
// depends on cbd_pkg; drives the handshakes and the datapath commands
`default_nettype none
module cbd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cbd_pkg::cbd_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_HOLD;
            ST_HOLD: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // handshakes and commands
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_HOLD);
    assign cmd.capture = (state_reg == ST_IDLE) && s_valid;
    assign cmd.execute = (state_reg == ST_EXEC);
    assign cmd.load    = (state_reg == ST_LOAD);

endmodule
`default_nettype wire

// ===== rtl/core/cbd_datapath.sv =====
// datapath of the console bus decoder: item registers, address decode,
// work ram, pad shifter, sprite dma state and result registers; uses cbd_pkg
`default_nettype none
module cbd_datapath #(
    parameter int RAM_BYTES = cbd_pkg::RAM_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cbd_pkg::cbd_cmd_t cmd,
    input  wire logic [1:0]        s_req_type,
    input  wire logic [15:0]       s_addr,
    input  wire logic [7:0]        s_wdata,
    input  wire logic              s_cart_hit,
    input  wire logic [7:0]        s_cart_rdata,
    input  wire logic [7:0]        s_ppu_rdata,
    input  wire logic [7:0]        s_pad0_buttons,
    output logic [7:0]             m_rdata,
    output logic [2:0]             m_target,
    output logic [15:0]            m_fwd_addr,
    output logic                   m_cpu_step,
    output logic                   m_oam_write,
    output logic [7:0]             m_oam_index,
    output logic [7:0]             m_oam_data,
    output logic                   m_dma_busy
);

    localparam int RAM_AW    = $clog2(RAM_BYTES);
    localparam int MOD_STEPS = $clog2(cbd_pkg::RAM_SPAN / RAM_BYTES) + 1;
    localparam logic [14:0] RAM_SIZE = 15'(RAM_BYTES);

    // mirror a ram window address onto the ram by shift-and-subtract
    function automatic logic [RAM_AW-1:0] ram_mirror(input logic [12:0] a);
        logic [14:0] r;
        r = {2'b00, a};
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (r >= (RAM_SIZE << k)) r = r - (RAM_SIZE << k);
        end
        return r[RAM_AW-1:0];
    endfunction

    // captured transaction
    logic [1:0]  req_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic        hit_reg;
    logic [7:0]  crd_reg;
    logic [7:0]  prd_reg;
    logic [7:0]  btn_reg;

    // block state
    logic [7:0]  pad_shift_reg,  pad_shift_next;
    logic [7:0]  dma_page_reg,   dma_page_next;
    logic [7:0]  dma_offset_reg, dma_offset_next;
    logic [7:0]  dma_byte_reg;
    logic        dma_waiting_reg, dma_waiting_next;
    logic        dma_running_reg, dma_running_next;
    logic [2:0]  phase_reg, phase_next;

    // result registers
    logic [7:0]  rdval_reg,  rdval_next;
    logic        rdram_reg,  rdram_next;
    logic        dmard_reg,  dmard_next;
    logic [7:0]  rdata_reg;
    logic [2:0]  tgt_reg,    tgt_next;
    logic [15:0] fwd_reg,    fwd_next;
    logic        step_reg,   step_next;
    logic        ow_reg,     ow_next;
    logic [7:0]  oidx_reg,   oidx_next;
    logic [7:0]  odat_reg,   odat_next;
    logic        busy_reg;

    // work ram
    logic [7:0]        ram_mem [RAM_BYTES];
    logic [7:0]        ram_q;
    logic [RAM_AW-1:0] ram_idx;
    logic              ram_we;

    // bus read decode
    logic [15:0] ba;
    logic [2:0]  rd_tgt;
    logic [15:0] rd_fwd;
    logic [7:0]  rd_val;
    logic        rd_ram;
    logic        rd_pad;

    // write decode
    logic [2:0]  wr_tgt;
    logic [15:0] wr_fwd;
    logic        wr_ram;
    logic        wr_dma;
    logic        wr_pad;

    logic        slot;
    logic        dma_read;
    logic        oam_wr;

    // capture of the incoming transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= s_req_type;
            addr_reg  <= s_addr;
            wdata_reg <= s_wdata;
            hit_reg   <= s_cart_hit;
            crd_reg   <= s_cart_rdata;
            prd_reg   <= s_ppu_rdata;
            btn_reg   <= s_pad0_buttons;
        end
    end

    // bus address: dma source page:offset on a tick, cpu address otherwise
    assign ba      = (req_reg == cbd_pkg::REQ_TICK) ? {dma_page_reg, dma_offset_reg} : addr_reg;
    assign ram_idx = ram_mirror(ba[12:0]);

    // read decode in priority order
    always_comb begin
        rd_tgt = cbd_pkg::TGT_NONE;
        rd_fwd = 16'h0000;
        rd_val = 8'h00;
        rd_ram = 1'b0;
        rd_pad = 1'b0;
        if (hit_reg) begin
            rd_tgt = cbd_pkg::TGT_CART;
            rd_fwd = ba;
            rd_val = crd_reg;
        end else if (ba <= cbd_pkg::ADDR_RAM_LAST) begin
            rd_tgt = cbd_pkg::TGT_RAM;
            rd_fwd = {{(16 - RAM_AW){1'b0}}, ram_idx};
            rd_ram = 1'b1;
        end else if (ba <= cbd_pkg::ADDR_PPU_LAST) begin
            rd_tgt = cbd_pkg::TGT_PPU;
            rd_fwd = {13'h0000, ba[2:0]};
            rd_val = prd_reg;
        end else if (ba == cbd_pkg::ADDR_PAD0) begin
            rd_tgt = cbd_pkg::TGT_PAD;
            rd_fwd = ba;
            rd_val = {7'h00, pad_shift_reg[7]};
            rd_pad = 1'b1;
        end else if (ba == cbd_pkg::ADDR_PAD1) begin
            rd_tgt = cbd_pkg::TGT_PAD;
            rd_fwd = ba;
        end
    end

    // write decode in priority order
    always_comb begin
        wr_tgt = cbd_pkg::TGT_NONE;
        wr_fwd = 16'h0000;
        wr_ram = 1'b0;
        wr_dma = 1'b0;
        wr_pad = 1'b0;
        if (hit_reg) begin
            wr_tgt = cbd_pkg::TGT_CART;
            wr_fwd = addr_reg;
        end else if (addr_reg <= cbd_pkg::ADDR_RAM_LAST) begin
            wr_tgt = cbd_pkg::TGT_RAM;
            wr_fwd = {{(16 - RAM_AW){1'b0}}, ram_idx};
            wr_ram = 1'b1;
        end else if (addr_reg <= cbd_pkg::ADDR_PPU_LAST) begin
            wr_tgt = cbd_pkg::TGT_PPU;
            wr_fwd = {13'h0000, addr_reg[2:0]};
        end else if (addr_reg <= cbd_pkg::ADDR_APU_LAST || addr_reg == cbd_pkg::ADDR_APU_STAT
                     || addr_reg == cbd_pkg::ADDR_PAD1) begin
            wr_tgt = cbd_pkg::TGT_APU;
            wr_fwd = addr_reg;
        end else if (addr_reg == cbd_pkg::ADDR_OAM_DMA) begin
            wr_tgt = cbd_pkg::TGT_DMA;
            wr_fwd = addr_reg;
            wr_dma = 1'b1;
        end else if (addr_reg == cbd_pkg::ADDR_PAD0) begin
            wr_tgt = cbd_pkg::TGT_PAD;
            wr_fwd = addr_reg;
            wr_pad = 1'b1;
        end
    end

    // tick slot decisions
    assign slot     = (phase_reg == cbd_pkg::PHASE_EVEN) || (phase_reg == cbd_pkg::PHASE_ODD);
    assign dma_read = slot && dma_running_reg && !dma_waiting_reg
                      && (phase_reg == cbd_pkg::PHASE_EVEN);
    assign oam_wr   = slot && dma_running_reg && !dma_waiting_reg
                      && (phase_reg == cbd_pkg::PHASE_ODD);

    // state update and result of one transaction
    always_comb begin
        pad_shift_next   = pad_shift_reg;
        dma_page_next    = dma_page_reg;
        dma_offset_next  = dma_offset_reg;
        dma_waiting_next = dma_waiting_reg;
        dma_running_next = dma_running_reg;
        phase_next       = phase_reg;
        rdval_next       = 8'h00;
        rdram_next       = 1'b0;
        dmard_next       = 1'b0;
        tgt_next         = cbd_pkg::TGT_NONE;
        fwd_next         = 16'h0000;
        step_next        = 1'b0;
        ow_next          = 1'b0;
        odat_next        = 8'h00;
        case (req_reg)
            cbd_pkg::REQ_READ: begin
                tgt_next   = rd_tgt;
                fwd_next   = rd_fwd;
                rdval_next = rd_val;
                rdram_next = rd_ram;
                if (rd_pad) pad_shift_next = {pad_shift_reg[6:0], 1'b0};
            end
            cbd_pkg::REQ_WRITE: begin
                tgt_next = wr_tgt;
                fwd_next = wr_fwd;
                if (wr_dma) begin
                    dma_page_next    = wdata_reg;
                    dma_offset_next  = 8'h00;
                    dma_running_next = 1'b1;
                end
                if (wr_pad) pad_shift_next = btn_reg;
            end
            cbd_pkg::REQ_TICK: begin
                phase_next = (phase_reg == cbd_pkg::PHASE_LAST) ? 3'd0 : 3'(phase_reg + 3'd1);
                if (slot && !dma_running_reg) step_next = 1'b1;
                if (slot && dma_running_reg && dma_waiting_reg
                    && phase_reg == cbd_pkg::PHASE_ODD) begin
                    dma_waiting_next = 1'b0;
                end
                if (dma_read) begin
                    tgt_next   = rd_tgt;
                    fwd_next   = rd_fwd;
                    rdval_next = rd_val;
                    rdram_next = rd_ram;
                    dmard_next = 1'b1;
                    if (rd_pad) pad_shift_next = {pad_shift_reg[6:0], 1'b0};
                end
                if (oam_wr) begin
                    ow_next         = 1'b1;
                    odat_next       = dma_byte_reg;
                    dma_offset_next = 8'(dma_offset_reg + 8'd1);
                    if (dma_offset_reg == 8'hFF) begin
                        dma_running_next = 1'b0;
                        dma_waiting_next = 1'b1;
                    end
                end
            end
            default: begin
                tgt_next = cbd_pkg::TGT_NONE;
            end
        endcase
        oidx_next = ow_next ? dma_offset_reg : dma_offset_next;
    end

    // work ram port: write on a cpu write, registered read every execute
    assign ram_we = cmd.execute && (req_reg == cbd_pkg::REQ_WRITE) && wr_ram;

    always_ff @(posedge aclk) begin
        if (ram_we) ram_mem[ram_idx] <= wdata_reg;
        if (cmd.execute) ram_q <= ram_mem[ram_idx];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_shift_reg   <= 8'h00;
            dma_page_reg    <= 8'h00;
            dma_offset_reg  <= 8'h00;
            dma_byte_reg    <= 8'h00;
            dma_waiting_reg <= 1'b1;
            dma_running_reg <= 1'b0;
            phase_reg       <= 3'd0;
        end else begin
            if (cmd.execute) begin
                pad_shift_reg   <= pad_shift_next;
                dma_page_reg    <= dma_page_next;
                dma_offset_reg  <= dma_offset_next;
                dma_waiting_reg <= dma_waiting_next;
                dma_running_reg <= dma_running_next;
                phase_reg       <= phase_next;
            end
            if (cmd.load && dmard_reg) begin
                dma_byte_reg <= rdram_reg ? ram_q : rdval_reg;
            end
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            rdval_reg <= rdval_next;
            rdram_reg <= rdram_next;
            dmard_reg <= dmard_next;
            tgt_reg   <= tgt_next;
            fwd_reg   <= fwd_next;
            step_reg  <= step_next;
            ow_reg    <= ow_next;
            oidx_reg  <= oidx_next;
            odat_reg  <= odat_next;
            busy_reg  <= dma_running_next;
        end
        if (cmd.load) begin
            rdata_reg <= rdram_reg ? ram_q : rdval_reg;
        end
    end

    assign m_rdata     = rdata_reg;
    assign m_target    = tgt_reg;
    assign m_fwd_addr  = fwd_reg;
    assign m_cpu_step  = step_reg;
    assign m_oam_write = ow_reg;
    assign m_oam_index = oidx_reg;
    assign m_oam_data  = odat_reg;
    assign m_dma_busy  = busy_reg;

endmodule
`default_nettype wire

// ===== rtl/core/console_bus_decode_with_sprite_dma_unit.sv =====
// console bus decoder with sprite dma: cpu reads, cpu writes and system ticks in,
// one result per transaction out; depends on cbd_pkg, cbd_ctrl and cbd_datapath
//
// input channel (s_*): one transaction is a cpu read, a cpu write or one system
// clock tick, with the cartridge claim, cartridge and ppu read data and the live
// pad 0 buttons sampled alongside it.
// result channel (m_*): exactly one result per transaction, in order: read data,
// decode target, forwarded address, cpu step and oam write strobes, oam index
// and data, and the dma busy flag after the transaction.
// sequence: in the execute state the transaction is decoded, state is updated and
// the work ram read is registered; in the load state the read data is registered;
// the result is then valid in the hold state until it is taken. the controller takes
// a new transaction only after the previous result is taken.
// a stalled receiver holds the result and s_ready stays low until it is taken.
// reset (aresetn low, synchronous): phase counter, pad shifter and dma state
// are cleared, dma waits for an odd slot; work ram contents are not cleared.
`default_nettype none
module console_bus_decode_with_sprite_dma_unit #(
    parameter int RAM_BYTES = cbd_pkg::RAM_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [15:0] s_addr,
    input  wire logic [7:0]  s_wdata,
    input  wire logic        s_cart_hit,
    input  wire logic [7:0]  s_cart_rdata,
    input  wire logic [7:0]  s_ppu_rdata,
    input  wire logic [7:0]  s_pad0_buttons,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_rdata,
    output logic [2:0]       m_target,
    output logic [15:0]      m_fwd_addr,
    output logic             m_cpu_step,
    output logic             m_oam_write,
    output logic [7:0]       m_oam_index,
    output logic [7:0]       m_oam_data,
    output logic             m_dma_busy
);

    cbd_pkg::cbd_cmd_t cmd;

    // sequencing
    cbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // decode, storage and results
    cbd_datapath #(
        .RAM_BYTES (RAM_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_req_type     (s_req_type),
        .s_addr         (s_addr),
        .s_wdata        (s_wdata),
        .s_cart_hit     (s_cart_hit),
        .s_cart_rdata   (s_cart_rdata),
        .s_ppu_rdata    (s_ppu_rdata),
        .s_pad0_buttons (s_pad0_buttons),
        .m_rdata        (m_rdata),
        .m_target       (m_target),
        .m_fwd_addr     (m_fwd_addr),
        .m_cpu_step     (m_cpu_step),
        .m_oam_write    (m_oam_write),
        .m_oam_index    (m_oam_index),
        .m_oam_data     (m_oam_data),
        .m_dma_busy     (m_dma_busy)
    );

endmodule
`default_nettype wire

// ===== dv/console_bus_decode_with_sprite_dma_unit_test.sv =====
// self-checking testbench of the console bus decoder with sprite dma
// depends on cbd_pkg and console_bus_decode_with_sprite_dma_unit; stimulus and prediction are local
module console_bus_decode_with_sprite_dma_unit_test;
    import cbd_pkg::*;

    localparam int RAM_BYTES = RAM_BYTES_DEF;
    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam int MAX_GAP = 13;
    localparam int ITEM_TARGET = 2000;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        cart_hit;
        logic [7:0]  cart_rdata;
        logic [7:0]  ppu_rdata;
        logic [7:0]  pad0_buttons;
    } bus_item_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [2:0]  target;
        logic [15:0] fwd_addr;
        logic        cpu_step;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        dma_busy;
    } bus_result_t;

    typedef struct packed {
        bus_item_t   item;
        logic        typed;
        bus_result_t result;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [15:0] s_addr;
    logic [7:0]  s_wdata;
    logic        s_cart_hit;
    logic [7:0]  s_cart_rdata;
    logic [7:0]  s_ppu_rdata;
    logic [7:0]  s_pad0_buttons;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_rdata;
    logic [2:0]  m_target;
    logic [15:0] m_fwd_addr;
    logic        m_cpu_step;
    logic        m_oam_write;
    logic [7:0]  m_oam_index;
    logic [7:0]  m_oam_data;
    logic        m_dma_busy;

    // predicted machine state
    logic [7:0] ram_image [RAM_BYTES];
    bit         ram_written [RAM_BYTES];
    int         written_offsets[$];
    logic [7:0] pad_bits;
    logic [7:0] dma_page_reg;
    logic [7:0] dma_index;
    logic [7:0] dma_latch;
    logic       dma_wait;
    logic       dma_active;
    logic [2:0] slot_phase;

    bus_result_t pending_results[$];
    stim_row_t   directed_rows[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          stall_cycles = 0;
    bit          sender_no_idle = 1'b0;
    bit          receiver_no_idle = 1'b0;
    bit          full_dma_done = 1'b0;

    console_bus_decode_with_sprite_dma_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_addr         (s_addr),
        .s_wdata        (s_wdata),
        .s_cart_hit     (s_cart_hit),
        .s_cart_rdata   (s_cart_rdata),
        .s_ppu_rdata    (s_ppu_rdata),
        .s_pad0_buttons (s_pad0_buttons),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rdata        (m_rdata),
        .m_target       (m_target),
        .m_fwd_addr     (m_fwd_addr),
        .m_cpu_step     (m_cpu_step),
        .m_oam_write    (m_oam_write),
        .m_oam_index    (m_oam_index),
        .m_oam_data     (m_oam_data),
        .m_dma_busy     (m_dma_busy)
    );

    // clock, period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // read decode shared by cpu reads and dma reads; a pad 0 read shifts the latch
    function automatic logic [7:0] decode_bus_read(input logic [15:0] a, input logic hit,
                                                   input logic [7:0] crd, input logic [7:0] prd,
                                                   output logic [2:0] tgt,
                                                   output logic [15:0] fwd);
        logic [7:0] d;
        d = 8'h00;
        tgt = TGT_NONE;
        fwd = 16'h0000;
        if (hit) begin
            tgt = TGT_CART; fwd = a; d = crd;
        end else if (a <= ADDR_RAM_LAST) begin
            tgt = TGT_RAM; fwd = 16'(int'(a) % RAM_BYTES); d = ram_image[int'(a) % RAM_BYTES];
        end else if (a <= ADDR_PPU_LAST) begin
            tgt = TGT_PPU; fwd = a & 16'h0007; d = prd;
        end else if (a == ADDR_PAD0) begin
            tgt = TGT_PAD; fwd = a; d = {7'd0, pad_bits[7]};
            pad_bits = pad_bits << 1;
        end else if (a == ADDR_PAD1) begin
            tgt = TGT_PAD; fwd = a;
        end
        return d;
    endfunction

    // advance the predicted state by one transaction and return its result
    function automatic bus_result_t next_bus_result(input bus_item_t it);
        bus_result_t res;
        int          off;
        bit          index_set;
        res = '0;
        index_set = 1'b0;
        case (it.req_type)
            REQ_READ: begin
                res.rdata = decode_bus_read(it.addr, it.cart_hit, it.cart_rdata, it.ppu_rdata,
                                            res.target, res.fwd_addr);
            end
            REQ_WRITE: begin
                if (it.cart_hit) begin
                    res.target = TGT_CART; res.fwd_addr = it.addr;
                end else if (it.addr <= ADDR_RAM_LAST) begin
                    off = int'(it.addr) % RAM_BYTES;
                    res.target = TGT_RAM; res.fwd_addr = 16'(off);
                    ram_image[off] = it.wdata;
                    if (!ram_written[off]) begin
                        ram_written[off] = 1'b1;
                        written_offsets.push_back(off);
                    end
                end else if (it.addr <= ADDR_PPU_LAST) begin
                    res.target = TGT_PPU; res.fwd_addr = it.addr & 16'h0007;
                end else if (it.addr <= ADDR_APU_LAST || it.addr == ADDR_APU_STAT ||
                             it.addr == ADDR_PAD1) begin
                    res.target = TGT_APU; res.fwd_addr = it.addr;
                end else if (it.addr == ADDR_OAM_DMA) begin
                    res.target = TGT_DMA; res.fwd_addr = it.addr;
                    dma_page_reg = it.wdata; dma_index = 8'h00; dma_active = 1'b1;
                end else if (it.addr == ADDR_PAD0) begin
                    res.target = TGT_PAD; res.fwd_addr = it.addr;
                    pad_bits = it.pad0_buttons;
                end
            end
            REQ_TICK: begin
                // cpu slots on the even and odd phases, unless dma owns them
                if (slot_phase == PHASE_EVEN || slot_phase == PHASE_ODD) begin
                    if (!dma_active) begin
                        res.cpu_step = 1'b1;
                    end else if (dma_wait) begin
                        if (slot_phase == PHASE_ODD) dma_wait = 1'b0;
                    end else if (slot_phase == PHASE_EVEN) begin
                        dma_latch = decode_bus_read({dma_page_reg, dma_index}, it.cart_hit,
                                                    it.cart_rdata, it.ppu_rdata,
                                                    res.target, res.fwd_addr);
                        res.rdata = dma_latch;
                    end else begin
                        res.oam_write = 1'b1;
                        res.oam_data = dma_latch;
                        res.oam_index = dma_index;
                        index_set = 1'b1;
                        dma_index = dma_index + 8'd1;
                        if (dma_index == 8'h00) begin
                            dma_active = 1'b0;
                            dma_wait = 1'b1;
                        end
                    end
                end
                slot_phase = (slot_phase == PHASE_LAST) ? 3'd0 : slot_phase + 3'd1;
            end
            default: begin
            end
        endcase
        if (!index_set) res.oam_index = dma_index;
        res.dma_busy = dma_active;
        return res;
    endfunction

    // a read of never-written work ram is not allowed: let the cartridge claim it instead
    function automatic bus_item_t guard_ram_read(input bus_item_t it);
        logic [15:0] a;
        bit          reads;
        reads = 1'b0;
        a = it.addr;
        if (it.req_type == REQ_READ) begin
            reads = 1'b1;
        end else if (it.req_type == REQ_TICK && dma_active && !dma_wait &&
                     slot_phase == PHASE_EVEN) begin
            reads = 1'b1;
            a = {dma_page_reg, dma_index};
        end
        if (reads && !it.cart_hit && a <= ADDR_RAM_LAST && !ram_written[int'(a) % RAM_BYTES])
            it.cart_hit = 1'b1;
        return it;
    endfunction

    function automatic bus_item_t mk_item(input logic [1:0] req, input logic [15:0] a,
                                          input logic [7:0] wd, input logic hit,
                                          input logic [7:0] crd, input logic [7:0] prd,
                                          input logic [7:0] btn);
        bus_item_t it;
        it.req_type = req; it.addr = a; it.wdata = wd; it.cart_hit = hit;
        it.cart_rdata = crd; it.ppu_rdata = prd; it.pad0_buttons = btn;
        return it;
    endfunction

    function automatic bus_result_t mk_res(input logic [7:0] rd, input logic [2:0] tgt,
                                           input logic [15:0] fwd, input logic step,
                                           input logic ow, input logic [7:0] oidx,
                                           input logic [7:0] odat, input logic busy);
        bus_result_t r;
        r.rdata = rd; r.target = tgt; r.fwd_addr = fwd; r.cpu_step = step;
        r.oam_write = ow; r.oam_index = oidx; r.oam_data = odat; r.dma_busy = busy;
        return r;
    endfunction

    function automatic logic [15:0] random_addr(input bit for_read);
        int region;
        region = $urandom_range(0, 9);
        if (region <= 2) begin
            if (for_read && written_offsets.size() != 0)
                return 16'(written_offsets[$urandom_range(0, written_offsets.size() - 1)] +
                           RAM_BYTES * $urandom_range(0, RAM_SPAN / RAM_BYTES - 1));
            return 16'($urandom_range(0, int'(ADDR_RAM_LAST)));
        end
        if (region <= 4) return 16'($urandom_range(int'(ADDR_RAM_LAST) + 1, int'(ADDR_PPU_LAST)));
        if (region <= 6) return 16'($urandom_range(int'(ADDR_PPU_LAST) + 1, int'(ADDR_PAD1)));
        if (region == 7) return 16'($urandom_range(int'(ADDR_PAD1) + 1, 16'hFFFF));
        return 16'($urandom);
    endfunction

    function automatic bus_item_t random_tick();
        return mk_item(REQ_TICK, 16'($urandom), 8'($urandom), $urandom_range(0, 3) == 0,
                       8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic bus_item_t random_bus_item();
        int          sel;
        logic [1:0]  req;
        sel = $urandom_range(0, 99);
        if (sel < 40) req = REQ_READ;
        else if (sel < 75) req = REQ_WRITE;
        else if (sel < 95) req = REQ_TICK;
        else req = REQ_RESERVED;
        return mk_item(req, random_addr(req == REQ_READ), 8'($urandom),
                       $urandom_range(0, 3) == 0, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic int draw_gap(input bit no_idle);
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // drive one transaction at the falling edge, wait for its acceptance, record its result
    task automatic send_item(input bus_item_t raw, input bit typed, input bus_result_t typed_res);
        bus_item_t   it;
        bus_result_t res;
        int          gap;
        it = guard_ram_read(raw);
        if ($urandom_range(0, 49) == 0) sender_no_idle = !sender_no_idle;
        gap = draw_gap(sender_no_idle);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type = it.req_type;
        s_addr = it.addr;
        s_wdata = it.wdata;
        s_cart_hit = it.cart_hit;
        s_cart_rdata = it.cart_rdata;
        s_ppu_rdata = it.ppu_rdata;
        s_pad0_buttons = it.pad0_buttons;
        s_valid = 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        res = next_bus_result(it);
        pending_results.push_back(typed ? typed_res : res);
        if (it.req_type != REQ_RESERVED) items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // pad latch followed by a serial read-out
    task automatic run_pad_sequence();
        int n;
        n = $urandom_range(6, 10);
        send_item(mk_item(REQ_WRITE, ADDR_PAD0, 8'($urandom), 1'b0, 8'($urandom),
                          8'($urandom), 8'($urandom)), 1'b0, '0);
        repeat (n)
            send_item(mk_item(REQ_READ, ($urandom_range(0, 7) == 0) ? ADDR_PAD1 : ADDR_PAD0,
                              8'($urandom), $urandom_range(0, 9) == 0, 8'($urandom),
                              8'($urandom), 8'($urandom)), 1'b0, '0);
    endtask

    // consecutive work ram writes so that later reads and dma find data
    task automatic run_ram_block_write();
        int start;
        int len;
        start = $urandom_range(0, int'(ADDR_RAM_LAST));
        len = $urandom_range(8, 64);
        for (int i = 0; i < len; i++)
            send_item(mk_item(REQ_WRITE, 16'((start + i) % RAM_SPAN), 8'($urandom), 1'b0,
                              8'($urandom), 8'($urandom), 8'($urandom)), 1'b0, '0);
    endtask

    // start a sprite transfer and tick it; cpu accesses are mixed into partial runs only
    task automatic run_sprite_dma(input bit to_end);
        logic [7:0] page;
        int         ticks;
        case ($urandom_range(0, 3))
            0: page = 8'($urandom_range(0, 8'h1F));
            1: page = 8'($urandom_range(8'h20, 8'h3F));
            2: page = 8'h40;
            default: page = 8'($urandom);
        endcase
        send_item(mk_item(REQ_WRITE, ADDR_OAM_DMA, page, 1'b0, 8'($urandom), 8'($urandom),
                          8'($urandom)), 1'b0, '0);
        ticks = $urandom_range(16, 200);
        while (to_end ? dma_active : ticks > 0) begin
            if (!to_end && $urandom_range(0, 9) == 0) send_item(random_bus_item(), 1'b0, '0);
            else send_item(random_tick(), 1'b0, '0);
            ticks--;
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic add_row(input bus_item_t it, input bit typed, input bus_result_t res);
        stim_row_t row;
        row.item = it;
        row.typed = typed;
        row.result = res;
        directed_rows.push_back(row);
    endtask

    // result monitor, sampled at the rising edge
    always @(posedge aclk) begin
        bus_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no expected result pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("rdata", want.rdata, m_rdata);
                compare_field("target", want.target, m_target);
                compare_field("fwd_addr", want.fwd_addr, m_fwd_addr);
                compare_field("cpu_step", want.cpu_step, m_cpu_step);
                compare_field("oam_write", want.oam_write, m_oam_write);
                compare_field("oam_index", want.oam_index, m_oam_index);
                compare_field("oam_data", want.oam_data, m_oam_data);
                compare_field("dma_busy", want.dma_busy, m_dma_busy);
            end
        end
    end

    // receiver: random stall before each result
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            if ($urandom_range(0, 49) == 0) receiver_no_idle = !receiver_no_idle;
            gap = draw_gap(receiver_no_idle);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("console_bus_decode_with_sprite_dma_unit_test: FAIL");
            $finish;
        end
    end

    // directed rows: result typed in where it is obvious, else predicted
    initial begin
        add_row(mk_item(REQ_TICK, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_NONE, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_WRITE, 16'h0000, 8'hA5, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_RAM, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_WRITE, 16'h1FFF, 8'h5A, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_RAM, 16'h07FF, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_READ, 16'h0800, 8'h00, 1'b0, 8'hFF, 8'hFF, 8'h00), 1'b1,
                mk_res(8'hA5, TGT_RAM, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_READ, 16'h17FF, 8'hFF, 1'b0, 8'h00, 8'h00, 8'hFF), 1'b1,
                mk_res(8'h5A, TGT_RAM, 16'h07FF, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_READ, 16'h2000, 8'h00, 1'b0, 8'h00, 8'hFF, 8'h00), 1'b1,
                mk_res(8'hFF, TGT_PPU, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_READ, 16'h3FFF, 8'h00, 1'b0, 8'hFF, 8'h00, 8'hFF), 1'b1,
                mk_res(8'h00, TGT_PPU, 16'h0007, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_WRITE, 16'h3FFF, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_PPU, 16'h0007, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_READ, 16'h8000, 8'h00, 1'b1, 8'hC3, 8'h00, 8'h00), 1'b1,
                mk_res(8'hC3, TGT_CART, 16'h8000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_WRITE, 16'hFFFF, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_CART, 16'hFFFF, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        // unmapped write and unmapped reads
        add_row(mk_item(REQ_WRITE, 16'hFFFF, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_NONE, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_READ, ADDR_APU_STAT, 8'h00, 1'b0, 8'hFF, 8'hFF, 8'h00), 1'b1,
                mk_res(8'h00, TGT_NONE, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_READ, 16'hFFFF, 8'h00, 1'b0, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                mk_res(8'h00, TGT_NONE, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        // apu writes
        add_row(mk_item(REQ_WRITE, 16'h4000, 8'h12, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_APU, 16'h4000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_WRITE, ADDR_APU_LAST, 8'h34, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_APU, ADDR_APU_LAST, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_WRITE, ADDR_APU_STAT, 8'h56, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_APU, ADDR_APU_STAT, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_WRITE, ADDR_PAD1, 8'h78, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_APU, ADDR_PAD1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        // pad 0 latch and shift, pad 1 read
        add_row(mk_item(REQ_WRITE, ADDR_PAD0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h81), 1'b1,
                mk_res(8'h00, TGT_PAD, ADDR_PAD0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_READ, ADDR_PAD0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h01, TGT_PAD, ADDR_PAD0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        add_row(mk_item(REQ_READ, ADDR_PAD0, 8'h00, 1'b0, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
        add_row(mk_item(REQ_READ, ADDR_PAD1, 8'h00, 1'b0, 8'h00, 8'h00, 8'hFF), 1'b1,
                mk_res(8'h00, TGT_PAD, ADDR_PAD1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        // unknown request changes nothing
        add_row(mk_item(REQ_RESERVED, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                mk_res(8'h00, TGT_NONE, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        // dma start, a tick, then a restart on another page
        add_row(mk_item(REQ_WRITE, ADDR_OAM_DMA, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_DMA, ADDR_OAM_DMA, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1));
        add_row(mk_item(REQ_TICK, 16'h0000, 8'h00, 1'b1, 8'h3C, 8'h00, 8'h00), 1'b0, '0);
        add_row(mk_item(REQ_WRITE, ADDR_OAM_DMA, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
                mk_res(8'h00, TGT_DMA, ADDR_OAM_DMA, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1));
    end

    // reset, directed rows, random scenarios, drain and verdict
    initial begin
        int pick;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = REQ_READ;
        s_addr = 16'h0000;
        s_wdata = 8'h00;
        s_cart_hit = 1'b0;
        s_cart_rdata = 8'h00;
        s_ppu_rdata = 8'h00;
        s_pad0_buttons = 8'h00;
        for (int i = 0; i < RAM_BYTES; i++) begin
            ram_image[i] = 8'h00;
            ram_written[i] = 1'b0;
        end
        pad_bits = 8'h00;
        dma_page_reg = 8'h00;
        dma_index = 8'h00;
        dma_latch = 8'h00;
        dma_wait = 1'b1;
        dma_active = 1'b0;
        slot_phase = 3'd0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

        // hold off the sender until the block has emptied at least once
        wait_for_results();
        while (items_sent < ITEM_TARGET) begin
            if (!full_dma_done && items_sent > 600) begin
                full_dma_done = 1'b1;
                run_sprite_dma(1'b1);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) send_item(random_bus_item(), 1'b0, '0);
            else if (pick < 60) run_pad_sequence();
            else if (pick < 75) run_ram_block_write();
            else if (pick < 94) run_sprite_dma(1'b0);
            else if (pick < 97) send_item(random_tick(), 1'b0, '0);
            else wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("console_bus_decode_with_sprite_dma_unit_test: PASS");
        else
            $display("console_bus_decode_with_sprite_dma_unit_test: FAIL");
        $finish;
    end

endmodule
